[sv/bjpq_pkg.sv]
// shared constants, codes and types for the blockable job priority queue
`timescale 1ns / 1ps
package bjpq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ID_W   = 16;
   localparam int PRIO_W = 10;
   localparam int ACT_W  = 2;
   localparam int ST_W   = 3;
   localparam int DATA_W = ((ID_W + PRIO_W + 7) / 8) * 8;
   localparam int PAD_W  = DATA_W - ID_W - PRIO_W;

   localparam logic [PRIO_W-1:0] RESTORE_RESET = PRIO_W'(999);

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_BLOCK   = 2'd2,
      ACT_UNBLOCK = 2'd3
   } action_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK          = 3'd0,
      ST_FULL        = 3'd1,
      ST_EMPTY       = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_NOT_BLOCKED = 3'd4,
      ST_NO_ELIGIBLE = 3'd5
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   job;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   job;
      logic [PRIO_W-1:0] prio;
   } result_type;

endpackage

[sv/bjpq_mem.sv]
// job slot memory, one write and one registered read port
`timescale 1ns / 1ps
module bjpq_mem
   import bjpq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type slots [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slots[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= slots[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bjpq_seq.sv]
// sequencer: scan, search, update and compaction over the slot memory
`timescale 1ns / 1ps
module bjpq_seq
   import bjpq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  action_type        req_action,
   input  logic [ID_W-1:0]   req_id,
   input  logic [PRIO_W-1:0] req_prio,
   input  logic [PRIO_W-1:0] restore_prio,
   output mem_req_type       mem_req,
   input  entry_type         mem_rd_data,
   output logic              res_valid,
   output result_type        res,
   input  logic              res_ready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   action_type       op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type        best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   result_type       res_ff, res_in;

   logic             at_last;
   logic             better;
   entry_type        nb;
   logic [IDX_W-1:0] nb_idx;
   logic             id_hit;

   always_comb begin
      at_last = CNT_W'(idx_ff) == (count_ff - CNT_W'(1));
      better  = mem_rd_data.prio > best_ff.prio;
      nb      = better ? mem_rd_data : best_ff;
      nb_idx  = better ? idx_ff : best_idx_ff;
      id_hit  = mem_rd_data.job == id_ff;

      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      res_in      = res_ff;
      mem_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_action;
               id_in       = req_id;
               idx_in      = '0;
               best_in     = '0;
               best_idx_in = '0;
               res_in      = '0;
               res_in.status = ST_OK;
               unique case (req_action)
                  ACT_ENQUEUE: begin
                     state_in = S_DONE;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_req.wr_en        = 1'b1;
                        mem_req.wr_addr      = count_ff[IDX_W-1:0];
                        mem_req.wr_data.job  = req_id;
                        mem_req.wr_data.prio = req_prio;
                        count_in             = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_in        = S_SCAN;
                     end
                  end
                  ACT_BLOCK, ACT_UNBLOCK: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_in        = S_SCAN;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (op_ff == ACT_DEQUEUE) begin
               best_in     = nb;
               best_idx_in = nb_idx;
               if (at_last) begin
                  if (nb.prio == '0) begin
                     res_in.status = ST_NO_ELIGIBLE;
                     state_in      = S_DONE;
                  end else begin
                     res_in.job  = nb.job;
                     res_in.prio = nb.prio;
                     if (CNT_W'(nb_idx) == (count_ff - CNT_W'(1))) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_DONE;
                     end else begin
                        // close the gap behind the removed job
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = nb_idx + IDX_W'(1);
                        idx_in          = nb_idx;
                        state_in        = S_MOVE;
                     end
                  end
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + IDX_W'(1);
                  idx_in          = idx_ff + IDX_W'(1);
               end
            end else begin
               if (id_hit) begin
                  state_in = S_DONE;
                  if (op_ff == ACT_BLOCK) begin
                     mem_req.wr_en        = 1'b1;
                     mem_req.wr_addr      = idx_ff;
                     mem_req.wr_data.job  = mem_rd_data.job;
                     mem_req.wr_data.prio = '0;
                  end else if (mem_rd_data.prio == '0) begin
                     mem_req.wr_en        = 1'b1;
                     mem_req.wr_addr      = idx_ff;
                     mem_req.wr_data.job  = mem_rd_data.job;
                     mem_req.wr_data.prio = restore_prio;
                  end else begin
                     res_in.status = ST_NOT_BLOCKED;
                  end
               end else if (at_last) begin
                  res_in.status = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + IDX_W'(1);
                  idx_in          = idx_ff + IDX_W'(1);
               end
            end
         end
         S_MOVE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = mem_rd_data;
            if ((CNT_W'(idx_ff) + CNT_W'(2)) == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + IDX_W'(2);
               idx_in          = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         op_ff       <= op_in;
         id_ff       <= id_in;
         idx_ff      <= idx_in;
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
         res_ff      <= res_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count beyond depth");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write of one slot in one cycle");

   a_deq_prio: assert property (@(posedge clock) disable iff (reset)
      (res_valid && op_ff == ACT_DEQUEUE && res.status == ST_OK) |-> (res.prio != '0))
      else $error("dequeued job with zero priority");

   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && op_ff != ACT_DEQUEUE) |-> (res.job == '0 && res.prio == '0))
      else $error("job fields set on a non-dequeue result");

   a_move_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && state_in == S_DONE) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("compaction did not drop one job");
`endif

endmodule

[sv/blockable_job_priority_queue.sv]
// Jobs sit in a 16-slot memory in arrival order and are worked on one request at a time.
// Dequeue, block and unblock walk the memory through its single registered read port,
// one slot a cycle: a dequeue scans every held job and then compacts by moving each job
// behind the removed one forward, and a block or unblock scans up to the first match (all
// held jobs when absent). The result sits in an output register, so the next request is
// taken while a result waits; restore priority is written through csr_wr_en.
`timescale 1ns / 1ps
module blockable_job_priority_queue
   import bjpq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // job_id, job_priority, zero pad
   input  logic [ACT_W-1:0]  req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // out_job_id, out_priority, zero pad
   output logic [ST_W-1:0]   rsp_tuser,   // status
   input  logic              csr_wr_en,
   input  logic [PRIO_W-1:0] csr_wr_data
);

   logic [PRIO_W-1:0] restore_ff;
   logic              rsp_valid_ff;
   result_type        rsp_res_ff;

   mem_req_type mem_req;
   entry_type   mem_rd_data;
   logic        res_valid;
   result_type  res;
   logic        res_ready;

   assign res_ready = !rsp_valid_ff || rsp_tready;

   bjpq_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (action_type'(req_tuser)),
      .req_id       (req_tdata[ID_W-1:0]),
      .req_prio     (req_tdata[ID_W+PRIO_W-1:ID_W]),
      .restore_prio (restore_ff),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_ready    (res_ready)
   );

   bjpq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         restore_ff   <= RESTORE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            restore_ff <= csr_wr_data;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
            rsp_res_ff   <= res;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_res_ff.prio, rsp_res_ff.job};
   assign rsp_tuser  = rsp_res_ff.status;

endmodule
